FILE: rtl/core/glmc_pkg.sv
// Shared constants, types and helpers for the grid local minimum counter.
package glmc_pkg;

    localparam int CELL_W      = 32;
    localparam int TOTAL_W     = 23;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 24;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int COLS_CFG_W  = 11;
    localparam int ROWS_CFG_W  = 13;

    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 4096;
    localparam int DEF_VALUE_BITS  = 32;

    localparam int unsigned CFG_COLS_RESET = 1024;
    localparam int unsigned CFG_ROWS_RESET = 4096;

    localparam logic [TOTAL_W-1:0] TALLY_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GRID_COLUMNS = 2'd0,
        REG_GRID_ROWS    = 2'd1
    } t_cfg_reg;

    // position of the incoming word within the grid
    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic last_row;
        logic col_ge1;
        logic col_ge2;
        logic last_col;
    } t_pos_flags;

    // last valid index for a size register: zero acts as one, oversize clamps
    function automatic int unsigned last_index(input int unsigned size,
                                               input int unsigned max_size);
        int unsigned res;
        if (size == 0) begin
            res = 0;
        end else if (size > max_size) begin
            res = max_size - 1;
        end else begin
            res = size - 1;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/glmc_scan.sv
// Grid size registers and raster position counters.
module glmc_scan #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [glmc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [glmc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_advance,
    output logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] o_col,
    output glmc_pkg::t_pos_flags             o_flags,
    output logic                             o_restart
);
    import glmc_pkg::*;

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [COL_W-1:0] COL_LAST_RST = COL_W'(last_index(CFG_COLS_RESET, MAX_COLUMNS));
    localparam logic [ROW_W-1:0] ROW_LAST_RST = ROW_W'(last_index(CFG_ROWS_RESET, MAX_ROWS));

    logic [COL_W-1:0] r_col_last, n_col_last;
    logic [ROW_W-1:0] r_row_last, n_row_last;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             w_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= COL_LAST_RST;
            r_row_last <= ROW_LAST_RST;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_col_last <= n_col_last;
            r_row_last <= n_row_last;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

    always_comb begin
        n_col_last = r_col_last;
        n_row_last = r_row_last;
        n_col      = r_col;
        n_row      = r_row;
        w_restart  = 1'b0;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_GRID_COLUMNS: begin
                    n_col_last = COL_W'(last_index(32'(i_cfg_wdata[COLS_CFG_W-1:0]),
                                                   MAX_COLUMNS));
                    w_restart  = 1'b1;
                end
                REG_GRID_ROWS: begin
                    n_row_last = ROW_W'(last_index(32'(i_cfg_wdata[ROWS_CFG_W-1:0]),
                                                   MAX_ROWS));
                    w_restart  = 1'b1;
                end
                default: begin
                    w_restart = 1'b0;
                end
            endcase
        end
        if (w_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (i_advance) begin
            if (r_col == r_col_last) begin
                n_col = '0;
                n_row = (r_row == r_row_last) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    assign o_col             = r_col;
    assign o_restart         = w_restart;
    assign o_flags.row_ge1   = (32'(r_row) >= 32'd1);
    assign o_flags.row_ge2   = (32'(r_row) >= 32'd2);
    assign o_flags.last_row  = (r_row == r_row_last);
    assign o_flags.col_ge1   = (32'(r_col) >= 32'd1);
    assign o_flags.col_ge2   = (32'(r_col) >= 32'd2);
    assign o_flags.last_col  = (r_col == r_col_last);

endmodule

FILE: rtl/core/glmc_window.sv
// Line store, neighbor window and per-word minimum decisions.
module glmc_window #(
    parameter int MAX_COLUMNS = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_accept,
    input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] i_col,
    input  glmc_pkg::t_pos_flags             i_flags,
    input  logic [glmc_pkg::CELL_W-1:0]      i_cell,
    output logic                             o_valid,
    output logic [2:0]                       o_inc,
    output logic                             o_last
);
    import glmc_pkg::*;

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int VB    = VALUE_BITS;
    localparam int EXT_W = (VALUE_BITS > CELL_W) ? VALUE_BITS : CELL_W;

    // entry per column: {row above, two rows above}, values sign-biased
    logic [2*VB-1:0]  r_line_mem [MAX_COLUMNS];
    logic [2*VB-1:0]  r_rd;
    logic [2*VB-1:0]  r_fwd;
    logic             r_hit;

    logic             r_s1_valid;
    logic [VB-1:0]    r_s1_v;
    logic [COL_W-1:0] r_s1_col;
    t_pos_flags       r_s1_flags;

    logic [VB-1:0]    r_p_v, r_p_mid, r_p_up;
    logic [VB-1:0]    r_q_v, r_q_mid;

    logic             r_s2_valid;
    logic [2:0]       r_s2_inc;
    logic             r_s2_last;

    logic [EXT_W-1:0] w_ext;
    logic [VB-1:0]    w_biased;
    logic [2*VB-1:0]  w_eff;
    logic [2*VB-1:0]  w_wdata;
    logic [VB-1:0]    w_em, w_eu;
    logic             w_dec_a, w_dec_b, w_dec_c, w_dec_d;
    logic [2:0]       w_inc;

    assign w_ext    = EXT_W'(i_cell);
    assign w_biased = w_ext[VB-1:0] ^ (VB'(1) << (VB - 1));

    assign w_eff   = r_hit ? r_fwd : r_rd;
    assign w_em    = w_eff[2*VB-1:VB];
    assign w_eu    = w_eff[VB-1:0];
    assign w_wdata = {r_s1_v, w_em};

    always_comb begin
        // cell above the previous word, right neighbor now known
        w_dec_a = r_s1_flags.col_ge1 && r_s1_flags.row_ge1 &&
                  (r_p_v > r_p_mid) &&
                  (!r_s1_flags.row_ge2 || (r_p_up > r_p_mid)) &&
                  (!r_s1_flags.col_ge2 || (r_q_mid > r_p_mid)) &&
                  (w_em > r_p_mid);
        // cell above a last-column word: no right neighbor
        w_dec_b = r_s1_flags.last_col && r_s1_flags.row_ge1 &&
                  (r_s1_v > w_em) &&
                  (!r_s1_flags.row_ge2 || (w_eu > w_em)) &&
                  (!r_s1_flags.col_ge1 || (r_p_mid > w_em));
        // last row: cell to the left
        w_dec_c = r_s1_flags.last_row && r_s1_flags.col_ge1 &&
                  (r_s1_v > r_p_v) &&
                  (!r_s1_flags.row_ge1 || (r_p_mid > r_p_v)) &&
                  (!r_s1_flags.col_ge2 || (r_q_v > r_p_v));
        // final cell of the grid
        w_dec_d = r_s1_flags.last_row && r_s1_flags.last_col &&
                  (!r_s1_flags.row_ge1 || (w_em > r_s1_v)) &&
                  (!r_s1_flags.col_ge1 || (r_p_v > r_s1_v));
        w_inc   = {2'b00, w_dec_a} + {2'b00, w_dec_b} + {2'b00, w_dec_c} + {2'b00, w_dec_d};
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_s1_valid) begin
            r_line_mem[r_s1_col] <= w_wdata;
        end
        if (i_accept) begin
            r_rd <= r_line_mem[i_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hit      <= r_s1_valid && (r_s1_col == i_col);
            r_fwd      <= w_wdata;
            r_s1_v     <= w_biased;
            r_s1_col   <= i_col;
            r_s1_flags <= i_flags;
        end
        if (i_en && r_s1_valid) begin
            r_q_v   <= r_p_v;
            r_q_mid <= r_p_mid;
            r_p_v   <= r_s1_v;
            r_p_mid <= w_em;
            r_p_up  <= w_eu;
        end
        if (i_en) begin
            r_s2_inc  <= w_inc;
            r_s2_last <= r_s1_flags.last_row && r_s1_flags.last_col;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_inc   = r_s2_inc;
    assign o_last  = r_s2_last;

endmodule

FILE: rtl/core/glmc_total.sv
// Saturating minima tally, output register and pipeline advance control.
module glmc_total (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic                          i_valid,
    input  logic [2:0]                    i_inc,
    input  logic                          i_last,
    input  logic                          i_m_tready,
    output logic                          o_en,
    output logic                          o_tvalid,
    output logic [glmc_pkg::TOTAL_W-1:0]  o_total
);
    import glmc_pkg::*;

    logic [TOTAL_W-1:0] r_tally;
    logic [TOTAL_W-1:0] r_total;
    logic               r_out_valid;
    logic [TOTAL_W:0]   w_sum;
    logic [TOTAL_W-1:0] w_sat;
    logic               w_en;

    // hold only when a new total would land on one still waiting
    assign w_en  = !(i_valid && i_last && r_out_valid && !i_m_tready);
    assign w_sum = {1'b0, r_tally} + (TOTAL_W + 1)'(i_inc);
    assign w_sat = w_sum[TOTAL_W] ? TALLY_MAX : w_sum[TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_tally <= '0;
            end else if (w_en && i_valid) begin
                r_tally <= i_last ? '0 : w_sat;
            end
            if (w_en && i_valid && i_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid && i_last) begin
            r_total <= w_sat;
        end
    end

    assign o_en     = w_en;
    assign o_tvalid = r_out_valid;
    assign o_total  = r_total;

endmodule

FILE: rtl/core/grid_local_minimum_counter_unit.sv
// Top level of the grid local minimum counter.
//
// Counts cells of a raster-order grid that are strictly smaller than all of
// their in-grid 4-neighbors and emits the total once per grid.
// Input channel s_axis: one signed cell value per word, row by row.
// Output channel m_axis: one word carrying the total after the last cell.
// Config port: i_cfg_we/i_cfg_addr/i_cfg_wdata set columns (0) and rows (1);
// a write restarts the grid. Zero acts as one, oversize clamps to maximum.
// Throughput: one word per cycle. Each word passes an input stage that reads
// the column line store, then a decision stage, then the tally/output
// register; the total is valid once the last cell's decision is registered there.
// A cell is decided once its in-grid lower and right neighbors have arrived.
// Reset: grid size 1024 x 4096, positions and tally cleared, output empty;
// line store contents are never used before being written in a grid.
// Stall: the pipeline keeps accepting while a total waits on m_axis; it
// holds (s_axis_tready low) only when a second total would overwrite it.
module grid_local_minimum_counter_unit #(
    parameter int MAX_COLUMNS = glmc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = glmc_pkg::DEF_MAX_ROWS,
    parameter int VALUE_BITS  = glmc_pkg::DEF_VALUE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [glmc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [glmc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [glmc_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [31:0] cell_value
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [glmc_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [22:0] minima_total, [23] zero
);
    import glmc_pkg::*;

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic               w_en;
    logic               w_accept;
    logic               w_restart;
    logic [COL_W-1:0]   w_col;
    t_pos_flags         w_flags;
    logic               w_dec_valid;
    logic [2:0]         w_dec_inc;
    logic               w_dec_last;
    logic [TOTAL_W-1:0] w_total;

    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && w_en;

    glmc_scan #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (w_accept),
        .o_col       (w_col),
        .o_flags     (w_flags),
        .o_restart   (w_restart)
    );

    glmc_window #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_accept (w_accept),
        .i_col    (w_col),
        .i_flags  (w_flags),
        .i_cell   (s_axis_tdata),
        .o_valid  (w_dec_valid),
        .o_inc    (w_dec_inc),
        .o_last   (w_dec_last)
    );

    glmc_total u_total (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (w_restart),
        .i_valid    (w_dec_valid),
        .i_inc      (w_dec_inc),
        .i_last     (w_dec_last),
        .i_m_tready (m_axis_tready),
        .o_en       (w_en),
        .o_tvalid   (m_axis_tvalid),
        .o_total    (w_total)
    );

    assign m_axis_tdata = M_TDATA_W'(w_total);

endmodule

FILE: rtl/core/glmc_checker.sv
// Port-level checks for the grid local minimum counter, bound to the top level.
module glmc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [glmc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [glmc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [glmc_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [31:0] cell_value
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [glmc_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [22:0] minima_total, [23] zero
);
    import glmc_pkg::*;

    logic w_unused;
    assign w_unused = i_cfg_we ^ (^i_cfg_addr) ^ (^i_cfg_wdata) ^ s_axis_tvalid ^
                      (^s_axis_tdata);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("total changed or dropped while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input held with no total waiting");

    a_hold_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input held without a stalled total");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("total valid right after reset");

endmodule

bind grid_local_minimum_counter_unit glmc_checker u_glmc_checker (.*);
